[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, codes and state encoding for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // Field widths of the request and response words.
   localparam int PAGE_W   = 52;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // The used map is stored as 32-bit words, one bit per page.
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;

   // Configuration port geometry: 64-bit registers at 8-byte spacing.
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_IDX_LSB = 3;
   localparam logic REG_HEAP_BASE = 1'b0;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   // Free-run counter saturates here; requests never ask for more.
   localparam logic [COUNT_W-1:0] RUN_MAX = '1;

   // Sequencer states.
   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_CHECK,
      FSM_SCAN,
      FSM_MARK,
      FSM_DONE
   } fsm_state_type;

endpackage

[src/bpa_req_if.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator request channel
// Valid/ready channel carrying one allocate or free request word.
// ----------------------------------------------------------------------------
interface bpa_req_if
   import bpa_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic               mode;
   logic [COUNT_W-1:0] page_count;
   logic [PAGE_W-1:0]  page_number;

   modport source (output valid, output mode, output page_count, output page_number,
                   input ready);
   modport sink   (input valid, input mode, input page_count, input page_number,
                   output ready);

endinterface

[src/bpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator response channel
// Valid/ready channel carrying one status word per request.
// ----------------------------------------------------------------------------
interface bpa_rsp_if
   import bpa_pkg::*;
   ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   first_page;

   modport source (output valid, output status, output first_page, input ready);
   modport sink   (input valid, input status, input first_page, output ready);

endinterface

[src/bpa_ram.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bitmap_page_allocator_core.sv]
// Allocate: the request word is taken and checked, map words are scanned up to
// the word where the run completes, each map word the run covers is marked, and
// the result is handed on. Free: as above without the scan, clearing covered words.
// The single read port of the map RAM sets the pace: one word read per cycle.
// One request is in flight at a time; a response waits in its output register.
// Reset (synchronous) starts a clear of every map word, with req.ready low.
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit page allocator over a used-page bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   bpa_req_if.sink               req,
   bpa_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OW        = $clog2(NUM_PAGES + 1);
   localparam int XW        = OW + AW + 6;
   localparam int TW        = COUNT_W + 1;
   localparam logic [AW:0]   LAST_WORD = (AW+1)'(MAP_WORDS - 1);
   localparam logic [XW-1:0] PAGES_X   = XW'(NUM_PAGES);

   // Registers.
   fsm_state_type       state_ff, state_in;
   logic [PAGE_W-1:0]   base_ff;
   logic                mode_ff, mode_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [PAGE_W-1:0]   off_ff, off_in;
   logic                below_ff, below_in;
   logic [AW:0]         rd_w_ff, rd_w_in;
   logic                vld_ff, vld_in;
   logic [AW:0]         proc_w_ff, proc_w_in;
   logic [COUNT_W-1:0]  run_ff, run_in;
   logic [XW-1:0]       lo_ff, lo_in;
   logic [XW-1:0]       hi_ff, hi_in;
   logic                set_ff, set_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PAGE_W-1:0]   first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_first_ff, rsp_first_in;

   // RAM port signals.
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;

   // Datapath signals.
   logic [XW-1:0]       word_base;
   logic [WORD_W-1:0]   used;
   logic [TW-1:0]       tot [WORD_W];
   logic [WORD_W-1:0]   hit;
   logic                hit_any;
   logic [BIT_W-1:0]    hit_pos;
   logic [COUNT_W-1:0]  run_next;
   logic [XW-1:0]       start_x;
   logic [XW-1:0]       hi_m1;
   logic [AW-1:0]       last_w;
   logic [WORD_W-1:0]   run_mask;
   logic [WORD_W-1:0]   mark_data;
   logic                range_bad;
   logic [PAGE_W:0]     page_diff;
   logic                csr_write;

   // Used-page map storage.
   bpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration port: one heap base register, writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_IDX_LSB] == REG_HEAP_BASE);
   assign csr_prdata = (csr_paddr[CSR_IDX_LSB] == REG_HEAP_BASE) ?
                       CSR_DATA_W'(base_ff) : '0;

   // Offset of the freed page from the heap base; the top bit is the borrow.
   assign page_diff = {1'b0, req.page_number} - {1'b0, base_ff};

   // Page index of bit 0 of the word that the RAM is returning.
   assign word_base = XW'({proc_w_ff[AW-1:0], {BIT_W{1'b0}}});

   // Pages past the end of the heap count as used.
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         used[b] = ram_rd_data[b] || ((word_base + XW'(b)) >= PAGES_X);
      end
   end

   // Free-run length ending at each bit, carrying the run from earlier words.
   always_comb begin : run_lengths
      logic            seen;
      logic [BIT_W-1:0] pos;
      for (int j = 0; j < WORD_W; j++) begin
         seen = 1'b0;
         pos  = '0;
         for (int k = 0; k <= j; k++) begin
            if (used[k]) begin
               seen = 1'b1;
               pos  = BIT_W'(k);
            end
         end
         if (used[j]) begin
            tot[j] = '0;
         end else if (seen) begin
            tot[j] = TW'(j) - TW'(pos);
         end else begin
            tot[j] = TW'(run_ff) + TW'(j + 1);
         end
         hit[j] = (tot[j] >= {1'b0, count_ff});
      end
   end

   // Lowest bit where the run reaches the requested count.
   always_comb begin
      hit_pos = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_pos = BIT_W'(j);
         end
      end
   end

   assign hit_any  = |hit;
   assign run_next = (tot[WORD_W-1] > TW'(RUN_MAX)) ? RUN_MAX :
                     tot[WORD_W-1][COUNT_W-1:0];
   assign start_x  = word_base + XW'(hit_pos) + XW'(1) - XW'(count_ff);

   // Word-level bounds and bit mask of the run being marked or cleared.
   assign hi_m1  = hi_ff - XW'(1);
   assign last_w = hi_m1[AW+BIT_W-1:BIT_W];

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         run_mask[b] = ((word_base + XW'(b)) >= lo_ff) && ((word_base + XW'(b)) < hi_ff);
      end
   end

   assign mark_data = set_ff ? (ram_rd_data | run_mask) : (ram_rd_data & ~run_mask);

   // A free must start inside the heap and end at or before its last page.
   assign range_bad = below_ff || (off_ff >= PAGE_W'(NUM_PAGES)) ||
                      ((XW'(off_ff[OW-1:0]) + XW'(count_ff)) > PAGES_X);

   // Sequencer: next state, RAM control and datapath register updates.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      below_in      = below_ff;
      rd_w_in       = rd_w_ff;
      vld_in        = 1'b0;
      proc_w_in     = proc_w_ff;
      run_in        = run_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_w_ff[AW-1:0];
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_w_ff[AW-1:0];
      req.ready     = 1'b0;

      case (state_ff)
         // Zero the map one word per cycle after reset.
         FSM_CLEAR: begin
            ram_wr_en = 1'b1;
            rd_w_in   = rd_w_ff + (AW+1)'(1);
            if (rd_w_ff == LAST_WORD) begin
               state_in = FSM_IDLE;
            end
         end

         // Take a request word and form the free offset.
         FSM_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               mode_in  = req.mode;
               count_in = req.page_count;
               off_in   = page_diff[PAGE_W-1:0];
               below_in = page_diff[PAGE_W];
               state_in = FSM_CHECK;
            end
         end

         // Screen out bad requests and set up the scan or the clear.
         FSM_CHECK: begin
            status_in = STATUS_OK;
            first_in  = '0;
            if (count_ff == '0) begin
               status_in = STATUS_NOSPACE;
               state_in  = FSM_DONE;
            end else if (mode_ff == MODE_ALLOC) begin
               if (XW'(count_ff) > PAGES_X) begin
                  status_in = STATUS_NOSPACE;
                  state_in  = FSM_DONE;
               end else begin
                  rd_w_in  = '0;
                  run_in   = '0;
                  state_in = FSM_SCAN;
               end
            end else if (range_bad) begin
               status_in = STATUS_RANGE;
               state_in  = FSM_DONE;
            end else begin
               lo_in    = XW'(off_ff[OW-1:0]);
               hi_in    = XW'(off_ff[OW-1:0]) + XW'(count_ff);
               set_in   = 1'b0;
               rd_w_in  = (AW+1)'(off_ff[OW-1:0] >> BIT_W);
               state_in = FSM_MARK;
            end
         end

         // Stream map words and look for the first free run long enough.
         FSM_SCAN: begin
            if (rd_w_ff <= LAST_WORD) begin
               ram_rd_en = 1'b1;
               rd_w_in   = rd_w_ff + (AW+1)'(1);
               vld_in    = 1'b1;
               proc_w_in = rd_w_ff;
            end
            if (vld_ff) begin
               if (hit_any) begin
                  lo_in    = start_x;
                  hi_in    = start_x + XW'(count_ff);
                  set_in   = 1'b1;
                  rd_w_in  = {1'b0, start_x[AW+BIT_W-1:BIT_W]};
                  vld_in   = 1'b0;
                  state_in = FSM_MARK;
               end else if (proc_w_ff == LAST_WORD) begin
                  status_in = STATUS_NOSPACE;
                  state_in  = FSM_DONE;
               end else begin
                  run_in = run_next;
               end
            end
         end

         // Read, modify and write back every word the run touches.
         FSM_MARK: begin
            if (rd_w_ff <= {1'b0, last_w}) begin
               ram_rd_en = 1'b1;
               rd_w_in   = rd_w_ff + (AW+1)'(1);
               vld_in    = 1'b1;
               proc_w_in = rd_w_ff;
            end
            if (vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = proc_w_ff[AW-1:0];
               ram_wr_data = mark_data;
               if (proc_w_ff[AW-1:0] == last_w) begin
                  status_in = STATUS_OK;
                  first_in  = (mode_ff == MODE_ALLOC) ? (base_ff + PAGE_W'(lo_ff)) : '0;
                  state_in  = FSM_DONE;
               end
            end
         end

         // Hand the result to the output register once it is free.
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = (status_ff == STATUS_OK) ? first_ff : '0;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         rd_w_ff      <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_w_ff      <= rd_w_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            base_ff <= csr_pwdata[PAGE_W-1:0];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      count_ff      <= count_in;
      off_ff        <= off_in;
      below_ff      <= below_in;
      proc_w_ff     <= proc_w_in;
      run_ff        <= run_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      set_ff        <= set_in;
      status_ff     <= status_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
   end

   // Response channel.
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.first_page = rsp_first_ff;

endmodule

[src/bpa_checker.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Port-level checks on the allocator core, attached by a bind statement.
// ----------------------------------------------------------------------------
module bpa_checker
   import bpa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [PAGE_W-1:0]   rsp_first_page
);

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_first_page))
      else $error("response word changed while stalled");

   // Failed requests report page zero.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_first_page == '0))
      else $error("error response carries a nonzero page");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_NOSPACE) ||
                    (rsp_status == STATUS_RANGE))
      else $error("undefined status code");

   // One request at a time: ready drops right after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in progress");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_first_page (rsp.first_page)
);

[dv/bitmap_page_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Sends allocate and free request words through the valid/ready request
// channel and predicts every response from a bit-level copy of the used-page
// map and heap base kept here. Responses are checked in order, field by field.
// The heap base is moved through zero, the top page, wrap-around and random
// values over the APB port, and both channels stall at random.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core_tb
   import bpa_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES     = 1024;
   localparam int REG_SPARE     = 1;
   localparam int HOLD_OFF      = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 100;
   localparam longint LIMIT_NS  = 64'd5_000_000;

   // One response word as the block should return it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   first_page;
   } grant_type;

   // A run of pages handed out by an allocate, held as a heap offset.
   typedef struct {
      int unsigned offset;
      int unsigned count;
   } page_run_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   bitmap_page_allocator_core #(
      .NUM_PAGES (NUM_PAGES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the block state, plus bookkeeping for the run.
   logic [NUM_PAGES-1:0] page_in_use = '0;
   logic [PAGE_W-1:0]    heap_base   = '0;
   grant_type            expected_grants[$];
   page_run_type         live_runs[$];
   int                   error_count   = 0;
   int                   words_sent    = 0;
   int                   alloc_granted = 0;
   int                   free_done     = 0;
   int                   refused       = 0;
   bit                   idle_enable   = 1'b0;
   int unsigned          hold_off_cycles = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(LIMIT_NS);
      $display("Timeout waiting for the allocator to finish.");
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
   endtask

   // First-fit allocate or ranged free against the shadow map.
   function automatic grant_type compute_grant(input logic mode,
                                               input logic [COUNT_W-1:0] count,
                                               input logic [PAGE_W-1:0] page,
                                               output int unsigned start_off);
      grant_type         g;
      int unsigned       free_len;
      bit                found;
      logic [PAGE_W-1:0] offset;
      g.status     = STATUS_OK;
      g.first_page = '0;
      start_off    = 0;
      found        = 1'b0;
      free_len     = 0;
      if (count == 0) begin
         g.status = STATUS_NOSPACE;
      end else if (mode == MODE_ALLOC) begin
         // Counts above the heap size can never fit, so the scan is skipped.
         if (count <= NUM_PAGES) begin
            for (int p = 0; p < NUM_PAGES && !found; p++) begin
               if (page_in_use[p]) begin
                  free_len = 0;
               end else begin
                  free_len++;
                  if (free_len == count) begin
                     start_off = p + 1 - count;
                     found     = 1'b1;
                  end
               end
            end
         end
         if (found) begin
            for (int p = 0; p < count; p++) begin
               page_in_use[start_off + p] = 1'b1;
            end
            g.first_page = heap_base + PAGE_W'(start_off);
         end else begin
            g.status = STATUS_NOSPACE;
         end
      end else if (page < heap_base) begin
         g.status = STATUS_RANGE;
      end else begin
         offset = page - heap_base;
         if (offset >= NUM_PAGES || count > NUM_PAGES - offset) begin
            g.status = STATUS_RANGE;
         end else begin
            for (int p = 0; p < count; p++) begin
               page_in_use[offset + p] = 1'b0;
            end
         end
      end
      return g;
   endfunction

   // Offer one request word, wait for it to be taken, then predict its response.
   task automatic send_word(input logic mode, input logic [COUNT_W-1:0] count,
                            input logic [PAGE_W-1:0] page, output grant_type grant,
                            output int unsigned start_off);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.page_count  <= count;
      req_if.page_number <= page;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      grant = compute_grant(mode, count, page, start_off);
      expected_grants.push_back(grant);
      words_sent++;
      if (grant.status != STATUS_OK) begin
         refused++;
      end else if (mode == MODE_ALLOC) begin
         alloc_granted++;
      end else begin
         free_done++;
      end
   endtask

   task automatic issue_word(input logic mode, input logic [COUNT_W-1:0] count,
                             input logic [PAGE_W-1:0] page);
      grant_type   grant;
      int unsigned start_off;
      send_word(mode, count, page, grant, start_off);
   endtask

   // Stop offering and let every outstanding response come back.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready.
   task automatic csr_write(input int reg_idx, input logic [PAGE_W-1:0] value);
      logic [CSR_DATA_W-1:0] junk;
      junk = {$urandom(), $urandom()};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(reg_idx << CSR_IDX_LSB);
      csr_pwdata  <= {junk[CSR_DATA_W-1:PAGE_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_idx == int'(REG_HEAP_BASE)) begin
         heap_base = value;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // APB read of the heap base, compared with the shadow copy.
   task automatic csr_check_base();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(int'(REG_HEAP_BASE) << CSR_IDX_LSB);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[PAGE_W-1:0] !== heap_base) begin
         report_error($sformatf("heap base reads 0x%0h, expected 0x%0h",
                                csr_prdata[PAGE_W-1:0], heap_base));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_heap_base(input logic [PAGE_W-1:0] value);
      drain_responses();
      csr_write(int'(REG_HEAP_BASE), value);
      csr_check_base();
   endtask

   // Register access: reset value, a write to an unused index, both extremes.
   task automatic test_csr_access();
      drain_responses();
      csr_check_base();
      csr_write(REG_SPARE, PAGE_W'({$urandom(), $urandom()}));
      csr_check_base();
      set_heap_base('1);
      set_heap_base('0);
   endtask

   // Field extremes and the refusal cases with the heap at offset zero.
   task automatic test_directed_edges();
      // Zero counts are refused in both modes.
      issue_word(MODE_ALLOC, '0, '0);
      issue_word(MODE_FREE, '0, '0);
      issue_word(MODE_ALLOC, 11'd1, '1);
      // With page 0 taken the whole heap no longer fits; oversize never fits.
      issue_word(MODE_ALLOC, COUNT_W'(NUM_PAGES), '0);
      issue_word(MODE_ALLOC, COUNT_W'(NUM_PAGES + 1), '0);
      issue_word(MODE_ALLOC, '1, '1);
      issue_word(MODE_FREE, 11'd1, heap_base);
      // Fill the heap completely, then ask for one more page.
      issue_word(MODE_ALLOC, COUNT_W'(NUM_PAGES), '0);
      issue_word(MODE_ALLOC, 11'd1, '0);
      // Frees touching the top of the heap, in range and just past it.
      issue_word(MODE_FREE, 11'd1, heap_base + PAGE_W'(NUM_PAGES - 1));
      issue_word(MODE_FREE, 11'd1, heap_base + PAGE_W'(NUM_PAGES));
      issue_word(MODE_FREE, 11'd25, heap_base + PAGE_W'(NUM_PAGES - 24));
      issue_word(MODE_FREE, 11'd24, heap_base + PAGE_W'(NUM_PAGES - 24));
      // A three-page hole low in the map is skipped by a four-page request.
      issue_word(MODE_FREE, 11'd3, heap_base + PAGE_W'(10));
      issue_word(MODE_ALLOC, 11'd4, '0);
      issue_word(MODE_ALLOC, 11'd3, '0);
      issue_word(MODE_FREE, '1, '1);
      // Free everything twice; the second pass clears pages already free.
      issue_word(MODE_FREE, COUNT_W'(NUM_PAGES), heap_base);
      issue_word(MODE_FREE, COUNT_W'(NUM_PAGES), heap_base);
   endtask

   // Result pages wrap past the top of the page space; frees below the base.
   task automatic test_base_wrap();
      set_heap_base('1);
      issue_word(MODE_ALLOC, 11'd3, '0);
      issue_word(MODE_ALLOC, 11'd2, '0);
      issue_word(MODE_FREE, 11'd1, '0);
      issue_word(MODE_FREE, 11'd1, '1);
      issue_word(MODE_FREE, COUNT_W'(NUM_PAGES), '1);
      set_heap_base({1'b1, {(PAGE_W - 1){1'b0}}});
      issue_word(MODE_FREE, 11'd1, heap_base - PAGE_W'(1));
      issue_word(MODE_ALLOC, 11'd1, '0);
      issue_word(MODE_FREE, 11'd1, heap_base);
   endtask

   // Responses are held off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      idle_enable     = 1'b0;
      hold_off_cycles = HOLD_OFF;
      for (int n = 0; n < 16; n++) begin
         issue_word(MODE_ALLOC, 11'd1, '0);
      end
      issue_word(MODE_FREE, 11'd16, heap_base);
      idle_enable = 1'b1;
   endtask

   // Mostly allocate/free traffic over runs that were really granted, with
   // some malformed words mixed in. The map fills up, fragments and drains.
   task automatic test_random_traffic(input int n_words);
      grant_type             grant;
      int unsigned           start_off;
      int unsigned           pick;
      int unsigned           cnt;
      int unsigned           roll;
      logic [CSR_DATA_W-1:0] noise;
      page_run_type          run;
      for (int n = 0; n < n_words; n++) begin
         roll  = $urandom_range(0, 99);
         noise = {$urandom(), $urandom()};
         if (roll < 55) begin
            // Small runs dominate; a few large ones push the map toward full.
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               cnt = $urandom_range(1, 8);
            end else if (pick < 90) begin
               cnt = $urandom_range(9, 64);
            end else if (pick < 98) begin
               cnt = $urandom_range(65, 300);
            end else begin
               cnt = $urandom_range(301, NUM_PAGES);
            end
            send_word(MODE_ALLOC, COUNT_W'(cnt), noise[PAGE_W-1:0], grant, start_off);
            if (grant.status == STATUS_OK) begin
               live_runs.push_back('{offset: start_off, count: cnt});
            end
         end else if (roll < 85 && live_runs.size() != 0) begin
            pick = $urandom_range(0, live_runs.size() - 1);
            run  = live_runs[pick];
            live_runs.delete(pick);
            // Now and then only the tail of a run is returned.
            if (run.count > 1 && $urandom_range(0, 3) == 0) begin
               cnt        = $urandom_range(1, run.count - 1);
               run.offset = run.offset + run.count - cnt;
               run.count  = cnt;
            end
            send_word(MODE_FREE, COUNT_W'(run.count), heap_base + PAGE_W'(run.offset),
                      grant, start_off);
         end else if (roll < 86) begin
            send_word(MODE_FREE, COUNT_W'(NUM_PAGES), heap_base, grant, start_off);
            live_runs.delete();
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  send_word(MODE_ALLOC, noise[CSR_DATA_W-1 -: COUNT_W], noise[PAGE_W-1:0],
                            grant, start_off);
               end
               1: begin
                  send_word(MODE_FREE, noise[CSR_DATA_W-1 -: COUNT_W], noise[PAGE_W-1:0],
                            grant, start_off);
               end
               2: begin
                  // Frees from anywhere in the heap to just past its top.
                  send_word(MODE_FREE, COUNT_W'($urandom_range(0, 200)),
                            heap_base + PAGE_W'($urandom_range(0, NUM_PAGES + 64)),
                            grant, start_off);
               end
               3: begin
                  send_word(MODE_FREE, noise[CSR_DATA_W-1 -: COUNT_W],
                            heap_base - PAGE_W'($urandom_range(1, 4)), grant, start_off);
               end
               default: begin
                  send_word(noise[CSR_DATA_W-1], '0, noise[PAGE_W-1:0], grant, start_off);
               end
            endcase
         end
      end
   endtask

   // Response side: random stall bursts, and the long hold-off on request.
   initial begin : rsp_ready_driver
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_if.ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin : grant_checker
      grant_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_grants.size() == 0) begin
            report_error($sformatf("response with nothing outstanding: status %0d page 0x%0h",
                                   rsp_if.status, rsp_if.first_page));
         end else begin
            want = expected_grants.pop_front();
            if (rsp_if.status !== want.status) begin
               report_error($sformatf("status %0d, expected %0d",
                                      rsp_if.status, want.status));
            end
            if (rsp_if.first_page !== want.first_page) begin
               report_error($sformatf("first_page 0x%0h, expected 0x%0h",
                                      rsp_if.first_page, want.first_page));
            end
         end
      end
   end

   // Test sequence.
   initial begin : stimulus
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_ALLOC;
      req_if.page_count  <= '0;
      req_if.page_number <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      idle_enable = 1'b1;
      test_csr_access();
      test_directed_edges();
      test_base_wrap();
      test_backpressure();

      set_heap_base(PAGE_W'({$urandom(), $urandom()}));
      test_random_traffic(250);
      set_heap_base('1 - PAGE_W'(NUM_PAGES / 2 - 1));
      test_random_traffic(250);
      set_heap_base(PAGE_W'($urandom_range(1, 4095)));
      test_random_traffic(250);

      // Closing stretch at full rate on both sides.
      idle_enable = 1'b0;
      set_heap_base('0);
      test_random_traffic(250);
      drain_responses();

      $display("Covered %0d request words: %0d allocations granted, %0d frees, %0d refused.",
               words_sent, alloc_granted, free_done, refused);
      $display("Heap base moved through zero, the top page, wrap-around and random values.");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
